// ===== rtl/rlpenc_pkg.sv =====
// rlpenc_pkg: shared types, codes and helpers of the rlp item and list encoder
`timescale 1ns / 1ps

package rlpenc_pkg;

  localparam int LEN_W   = 32;
  localparam int INT_W   = 64;
  localparam int CNT_W   = 4;
  localparam int QDEPTH  = 4;

  localparam logic [1:0] OP_STR  = 2'd0;
  localparam logic [1:0] OP_INT  = 2'd1;
  localparam logic [1:0] OP_LIST = 2'd2;

  localparam logic [7:0] HDR_STR_SHORT  = 8'h80;
  localparam logic [7:0] HDR_STR_LONG   = 8'hb7;
  localparam logic [7:0] HDR_LIST_SHORT = 8'hc0;
  localparam logic [7:0] HDR_LIST_LONG  = 8'hf7;
  localparam logic [7:0] SINGLE_LIM     = 8'h80;
  localparam logic [7:0] SHORT_MAX      = 8'd55;

  // one request as the serialiser sees it: header, value bytes, data byte
  typedef struct packed {
    logic              hdr_en;
    logic [7:0]        hdr_byte;
    logic              hdr_end;
    logic [CNT_W-1:0]  nval;
    logic [INT_W-1:0]  val;
    logic              val_end;
    logic              data_en;
    logic [7:0]        data_byte;
    logic              data_end;
    logic [CNT_W-1:0]  total;
  } desc_t;

  // count of significant big-endian bytes
  function automatic logic [CNT_W-1:0] min_bytes(input logic [INT_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < INT_W / 8; i++) begin
      if (v[8*i +: 8] != 8'h00) begin
        n = CNT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/rlpenc_front.sv =====
// rlpenc_front: classifies an incoming request into a byte descriptor
`timescale 1ns / 1ps

module rlpenc_front import rlpenc_pkg::*; #(
  parameter int LEN_BYTES = 4
) (
  input  logic [1:0]       operation,
  input  logic [7:0]       data_byte,
  input  logic [LEN_W-1:0] payload_length,
  input  logic [INT_W-1:0] int_value,
  input  logic             first_byte,
  input  logic             last_byte,
  output logic             desc_valid,
  output desc_t            desc
);

  logic [LEN_W-1:0] lenm;
  logic [CNT_W-1:0] nlen;
  logic [CNT_W-1:0] nint;

  always_comb begin
    lenm = '0;
    for (int i = 0; i < LEN_W / 8; i++) begin
      if (i < LEN_BYTES) begin
        lenm[8*i +: 8] = payload_length[8*i +: 8];
      end
    end
  end

  assign nlen = min_bytes({{(INT_W-LEN_W){1'b0}}, lenm});
  assign nint = min_bytes(int_value);

  always_comb begin
    desc       = '0;
    desc_valid = 1'b0;
    case (operation)
      OP_STR: begin
        desc_valid     = 1'b1;
        desc.data_en   = 1'b1;
        desc.data_byte = data_byte;
        desc.data_end  = last_byte;
        if (first_byte) begin
          if (payload_length == '0) begin
            desc.data_en  = 1'b0;
            desc.hdr_en   = 1'b1;
            desc.hdr_byte = HDR_STR_SHORT;
            desc.hdr_end  = 1'b1;
          end else if (!(payload_length == LEN_W'(1) && data_byte < SINGLE_LIM)) begin
            desc.hdr_en = 1'b1;
            if (lenm <= LEN_W'(SHORT_MAX)) begin
              desc.hdr_byte = HDR_STR_SHORT + lenm[7:0];
            end else begin
              desc.hdr_byte = HDR_STR_LONG + 8'(nlen);
              desc.nval     = nlen;
              desc.val      = {{(INT_W-LEN_W){1'b0}}, lenm};
            end
          end
        end
      end
      OP_INT: begin
        desc_valid  = 1'b1;
        desc.hdr_en = 1'b1;
        if (int_value == '0) begin
          desc.hdr_byte = HDR_STR_SHORT;
          desc.hdr_end  = 1'b1;
        end else if (int_value < INT_W'(SINGLE_LIM)) begin
          desc.hdr_byte = int_value[7:0];
          desc.hdr_end  = 1'b1;
        end else begin
          desc.hdr_byte = HDR_STR_SHORT + 8'(nint);
          desc.nval     = nint;
          desc.val      = int_value;
          desc.val_end  = 1'b1;
        end
      end
      OP_LIST: begin
        desc_valid  = 1'b1;
        desc.hdr_en = 1'b1;
        if (lenm <= LEN_W'(SHORT_MAX)) begin
          desc.hdr_byte = HDR_LIST_SHORT + lenm[7:0];
          desc.hdr_end  = (payload_length == '0);
        end else begin
          desc.hdr_byte = HDR_LIST_LONG + 8'(nlen);
          desc.nval     = nlen;
          desc.val      = {{(INT_W-LEN_W){1'b0}}, lenm};
        end
      end
      default: begin
        desc_valid = 1'b0;
      end
    endcase
    desc.total = CNT_W'(desc.hdr_en) + desc.nval + CNT_W'(desc.data_en);
  end

endmodule

// ===== rtl/rlpenc_queue.sv =====
// rlpenc_queue: short descriptor queue between classifier and serialiser
`timescale 1ns / 1ps

module rlpenc_queue import rlpenc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  localparam int PTR_W = $clog2(QDEPTH);

  desc_t            mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == (PTR_W+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/rlpenc_back.sv =====
// rlpenc_back: serialises descriptors into bytes behind an output register
`timescale 1ns / 1ps

module rlpenc_back import rlpenc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  desc_t      head_desc,
  output logic       head_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_item_end
);

  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r;
  logic             olast_r, oend_r;

  logic [CNT_W-1:0] j, k;
  logic [7:0]       cur_byte;
  logic             cur_end, cur_last, adv;

  always_comb begin
    j        = pos_r - CNT_W'(head_desc.hdr_en);
    k        = head_desc.nval - 1'b1 - j;
    cur_last = (pos_r == head_desc.total - 1'b1);
    if (head_desc.hdr_en && pos_r == '0) begin
      cur_byte = head_desc.hdr_byte;
      cur_end  = head_desc.hdr_end;
    end else if (j < head_desc.nval) begin
      cur_byte = head_desc.val[{k[2:0], 3'b000} +: 8];
      cur_end  = head_desc.val_end && (k == '0);
    end else begin
      cur_byte = head_desc.data_byte;
      cur_end  = head_desc.data_end;
    end
  end

  assign adv      = head_valid && (!ovalid_r || out_pop);
  assign head_pop = adv && cur_last;

  always_comb begin
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r;
    if (adv) begin
      pos_nxt    = cur_last ? '0 : pos_r + 1'b1;
      ovalid_nxt = 1'b1;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      obyte_r <= cur_byte;
      olast_r <= cur_last;
      oend_r  <= cur_end;
    end
  end

  assign out_empty    = !ovalid_r;
  assign out_byte     = obyte_r;
  assign out_run_last = olast_r;
  assign out_item_end = oend_r;

endmodule

// ===== rtl/rlp_item_and_list_encoder.sv =====
// rlp_item_and_list_encoder: top level of the rlp byte-stream encoder
//
// Each request (string payload byte, integer, or list header) becomes one or
// more encoded bytes, one per result, in request order. The classifier takes a
// request every cycle into a four-entry descriptor queue; the serialiser emits
// one byte per cycle while results are popped, and a request yields one byte
// for a plain string byte, up to LEN_BYTES+2 for the first byte of a long
// string, up to nine for an integer. Requests keep arriving at one per cycle
// until the queue fills, and the output register lets a finished byte wait
// while the next one is prepared. A request with an unused operation code is
// dropped without any result.
`timescale 1ns / 1ps

module rlp_item_and_list_encoder import rlpenc_pkg::*; #(
  parameter int LEN_BYTES = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_payload_length,
  input  logic [INT_W-1:0] in_int_value,
  input  logic             in_first_byte,
  input  logic             in_last_byte,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_item_end
);

  desc_t front_desc, head_desc;
  logic  front_valid, head_valid, head_pop;

  rlpenc_front #(
    .LEN_BYTES(LEN_BYTES)
  ) u_front (
    .operation      (in_operation),
    .data_byte      (in_data_byte),
    .payload_length (in_payload_length),
    .int_value      (in_int_value),
    .first_byte     (in_first_byte),
    .last_byte      (in_last_byte),
    .desc_valid     (front_valid),
    .desc           (front_desc)
  );

  rlpenc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push && front_valid),
    .push_desc  (front_desc),
    .full       (in_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  rlpenc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_desc    (head_desc),
    .head_pop     (head_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_item_end (out_item_end)
  );

endmodule
